@@ src/button_debounce_chord_repeat_top_assert.svh @@
// Assertion macros used by the top-level RTL
`ifndef BUTTON_DEBOUNCE_CHORD_REPEAT_TOP_ASSERT_SVH
`define BUTTON_DEBOUNCE_CHORD_REPEAT_TOP_ASSERT_SVH

// same-cycle implication, quiet during reset
`define BDCR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bdcr: implication violated");

// next-cycle implication, quiet during reset
`define BDCR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bdcr: next-cycle implication violated");

`endif

@@ src/bdcr_pkg.sv @@
`timescale 1ns / 1ps

package bdcr_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_W  = 16;
    localparam int unsigned POS_W  = 3;
    localparam int unsigned IDX_W  = 3;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_UP    = 3'd1,
        EV_DOWN  = 3'd2,
        EV_POWER = 3'd3,
        EV_CHORD = 3'd4
    } t_event;

    localparam logic [IDX_W-1:0] CFG_DEBOUNCE   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_CHORD_HOLD = 3'd1;
    localparam logic [IDX_W-1:0] CFG_REP_DELAY  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_REP_INTVL  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_UP_POS     = 3'd4;
    localparam logic [IDX_W-1:0] CFG_DOWN_POS   = 3'd5;
    localparam logic [IDX_W-1:0] CFG_POWER_POS  = 3'd6;

    localparam logic [CFG_W-1:0] RST_DEBOUNCE   = 16'd30;
    localparam logic [CFG_W-1:0] RST_CHORD_HOLD = 16'd1000;
    localparam logic [CFG_W-1:0] RST_REP_DELAY  = 16'd450;
    localparam logic [CFG_W-1:0] RST_REP_INTVL  = 16'd300;
    localparam logic [POS_W-1:0] RST_UP_POS     = 3'd0;
    localparam logic [POS_W-1:0] RST_DOWN_POS   = 3'd1;
    localparam logic [POS_W-1:0] RST_POWER_POS  = 3'd2;

    typedef struct packed {
        logic level;
        logic level_nxt;
    } t_db_stat;

    function automatic logic elapsed(
        input logic [TIME_W-1:0] now,
        input logic [TIME_W-1:0] since,
        input logic [CFG_W-1:0]  limit
    );
        logic [TIME_W-1:0] diff;
        begin
            diff = now - since;
            elapsed = (diff >= {{(TIME_W-CFG_W){1'b0}}, limit});
        end
    endfunction

endpackage

@@ src/bdcr_debounce.sv @@
`timescale 1ns / 1ps

module bdcr_debounce (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_pressed,
    input  logic [bdcr_pkg::TIME_W-1:0]   i_now,
    input  logic [bdcr_pkg::CFG_W-1:0]    i_debounce,
    output bdcr_pkg::t_db_stat            o_stat
);

    logic                        r_raw;
    logic                        r_level;
    logic [bdcr_pkg::TIME_W-1:0] r_change;
    logic [bdcr_pkg::TIME_W-1:0] n_change;
    logic                        n_level;

    always_comb begin
        n_change = (r_raw != i_pressed) ? i_now : r_change;
        n_level  = bdcr_pkg::elapsed(i_now, n_change, i_debounce) ? i_pressed : r_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw    <= 1'b0;
            r_level  <= 1'b0;
            r_change <= '0;
        end else if (i_en) begin
            r_raw    <= i_pressed;
            r_level  <= n_level;
            r_change <= n_change;
        end
    end

    assign o_stat.level     = r_level;
    assign o_stat.level_nxt = n_level;

endmodule

@@ src/button_debounce_chord_repeat_top.sv @@
`timescale 1ns / 1ps
// Each accepted poll's event is written to the output register in the next cycle.
// Throughput: one poll per cycle unless o_ready is low; the debounce, chord and
// repeat compares are combinational between the input ports and output register.
// Reset (synchronous, active low): all buttons released, timers zero, registers
// at their defaults (30, 1000, 450, 300, bits 0, 1, 2), output empty.

`include "button_debounce_chord_repeat_top_assert.svh"

module button_debounce_chord_repeat_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_port_bits,
    input  logic [bdcr_pkg::TIME_W-1:0]   i_now_ms,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2:0]                    o_event_code,
    input  logic                          i_cfg_we,
    input  logic [bdcr_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [bdcr_pkg::CFG_W-1:0]    i_cfg_data
);

    logic [bdcr_pkg::CFG_W-1:0]  r_debounce;
    logic [bdcr_pkg::CFG_W-1:0]  r_chord_hold;
    logic [bdcr_pkg::CFG_W-1:0]  r_rep_delay;
    logic [bdcr_pkg::CFG_W-1:0]  r_rep_intvl;
    logic [bdcr_pkg::POS_W-1:0]  r_up_pos;
    logic [bdcr_pkg::POS_W-1:0]  r_down_pos;
    logic [bdcr_pkg::POS_W-1:0]  r_power_pos;

    logic                        r_chord_running;
    logic                        r_chord_done;
    logic [bdcr_pkg::TIME_W-1:0] r_chord_start;
    logic [bdcr_pkg::TIME_W-1:0] r_press [2];
    logic [bdcr_pkg::TIME_W-1:0] r_repeat [2];

    logic                        r_valid;
    bdcr_pkg::t_event            r_event;

    logic                        n_chord_running;
    logic                        n_chord_done;
    logic [bdcr_pkg::TIME_W-1:0] n_chord_start;
    bdcr_pkg::t_event            n_event;
    logic [1:0]                  n_stamp_press;
    logic [1:0]                  n_stamp_repeat;

    logic                        accept;
    logic [2:0]                  pressed;
    bdcr_pkg::t_db_stat          stat [3];
    logic [2:0]                  prev;
    logic [2:0]                  lvl;
    logic                        both;
    logic [1:0]                  edge_hit;
    logic [1:0]                  rep_hit;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    assign pressed[0] = ~i_port_bits[r_up_pos];
    assign pressed[1] = ~i_port_bits[r_down_pos];
    assign pressed[2] = ~i_port_bits[r_power_pos];

    for (genvar g = 0; g < 3; g++) begin : g_db
        bdcr_debounce u_db (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (accept),
            .i_pressed  (pressed[g]),
            .i_now      (i_now_ms),
            .i_debounce (r_debounce),
            .o_stat     (stat[g])
        );
        assign prev[g] = stat[g].level;
        assign lvl[g]  = stat[g].level_nxt;
    end

    assign both = lvl[0] && lvl[1];

    for (genvar b = 0; b < 2; b++) begin : g_btn
        assign edge_hit[b] = lvl[b] && !prev[b];
        assign rep_hit[b]  = lvl[b] && prev[b]
                           && bdcr_pkg::elapsed(i_now_ms, r_press[b], r_rep_delay)
                           && bdcr_pkg::elapsed(i_now_ms, r_repeat[b], r_rep_intvl);
    end

    always_comb begin
        n_chord_running = r_chord_running;
        n_chord_done    = r_chord_done;
        n_chord_start   = r_chord_start;
        n_event         = bdcr_pkg::EV_NONE;
        n_stamp_press   = 2'b00;
        n_stamp_repeat  = 2'b00;
        if (both) begin
            n_chord_running = 1'b1;
            if (!r_chord_running) begin
                n_chord_start = i_now_ms;
            end
            if (!r_chord_done
                && bdcr_pkg::elapsed(i_now_ms, n_chord_start, r_chord_hold)) begin
                n_chord_done = 1'b1;
                n_event      = bdcr_pkg::EV_CHORD;
            end
        end else begin
            n_chord_running = 1'b0;
            n_chord_done    = 1'b0;
        end
        if (n_event == bdcr_pkg::EV_NONE) begin
            if (lvl[2] && !prev[2]) begin
                n_event = bdcr_pkg::EV_POWER;
            end else if (!both) begin
                if (edge_hit[0] || rep_hit[0]) begin
                    n_event           = bdcr_pkg::EV_UP;
                    n_stamp_press[0]  = edge_hit[0];
                    n_stamp_repeat[0] = 1'b1;
                end else if (edge_hit[1] || rep_hit[1]) begin
                    n_event           = bdcr_pkg::EV_DOWN;
                    n_stamp_press[1]  = edge_hit[1];
                    n_stamp_repeat[1] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= bdcr_pkg::RST_DEBOUNCE;
            r_chord_hold <= bdcr_pkg::RST_CHORD_HOLD;
            r_rep_delay  <= bdcr_pkg::RST_REP_DELAY;
            r_rep_intvl  <= bdcr_pkg::RST_REP_INTVL;
            r_up_pos     <= bdcr_pkg::RST_UP_POS;
            r_down_pos   <= bdcr_pkg::RST_DOWN_POS;
            r_power_pos  <= bdcr_pkg::RST_POWER_POS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bdcr_pkg::CFG_DEBOUNCE:   r_debounce   <= i_cfg_data;
                bdcr_pkg::CFG_CHORD_HOLD: r_chord_hold <= i_cfg_data;
                bdcr_pkg::CFG_REP_DELAY:  r_rep_delay  <= i_cfg_data;
                bdcr_pkg::CFG_REP_INTVL:  r_rep_intvl  <= i_cfg_data;
                bdcr_pkg::CFG_UP_POS:     r_up_pos     <= i_cfg_data[bdcr_pkg::POS_W-1:0];
                bdcr_pkg::CFG_DOWN_POS:   r_down_pos   <= i_cfg_data[bdcr_pkg::POS_W-1:0];
                bdcr_pkg::CFG_POWER_POS:  r_power_pos  <= i_cfg_data[bdcr_pkg::POS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chord_running <= 1'b0;
            r_chord_done    <= 1'b0;
            r_chord_start   <= '0;
            r_press[0]      <= '0;
            r_press[1]      <= '0;
            r_repeat[0]     <= '0;
            r_repeat[1]     <= '0;
        end else if (accept) begin
            r_chord_running <= n_chord_running;
            r_chord_done    <= n_chord_done;
            r_chord_start   <= n_chord_start;
            for (int k = 0; k < 2; k++) begin
                if (n_stamp_press[k]) begin
                    r_press[k] <= i_now_ms;
                end
                if (n_stamp_repeat[k]) begin
                    r_repeat[k] <= i_now_ms;
                end
            end
        end
    end

    // hold the result until taken; refill on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_event <= bdcr_pkg::EV_NONE;
        end else if (o_ready) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_event <= n_event;
            end
        end
    end

    assign o_valid      = r_valid;
    assign o_event_code = r_event;

    `BDCR_ASSERT_NXT(a_chord_latch, accept && (n_event == bdcr_pkg::EV_CHORD), r_chord_done)
    `BDCR_ASSERT_IMP(a_done_running, r_chord_done, r_chord_running)
    `BDCR_ASSERT_NXT(a_power_level, accept && (n_event == bdcr_pkg::EV_POWER), stat[2].level)

endmodule

@@ dv/button_debounce_chord_repeat_top_tb.sv @@
`timescale 1ns / 1ps

module button_debounce_chord_repeat_top_tb;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned HOLDOFF_CYCLES = 400;

    typedef struct packed {
        logic [7:0]  port;
        logic [31:0] now;
    } t_poll;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic [7:0]                    i_port_bits = 8'hFF;
    logic [bdcr_pkg::TIME_W-1:0]   i_now_ms = '0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic [2:0]                    o_event_code;
    logic                          i_cfg_we = 1'b0;
    logic [bdcr_pkg::IDX_W-1:0]    i_cfg_idx = bdcr_pkg::CFG_DEBOUNCE;
    logic [bdcr_pkg::CFG_W-1:0]    i_cfg_data = '0;

    button_debounce_chord_repeat_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_port_bits  (i_port_bits),
        .i_now_ms     (i_now_ms),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_event_code (o_event_code),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // configuration register copy, reset state
    logic [bdcr_pkg::CFG_W-1:0]  cfg_db     = bdcr_pkg::RST_DEBOUNCE;
    logic [bdcr_pkg::CFG_W-1:0]  cfg_chord  = bdcr_pkg::RST_CHORD_HOLD;
    logic [bdcr_pkg::CFG_W-1:0]  cfg_delay  = bdcr_pkg::RST_REP_DELAY;
    logic [bdcr_pkg::CFG_W-1:0]  cfg_intvl  = bdcr_pkg::RST_REP_INTVL;
    logic [bdcr_pkg::POS_W-1:0]  pos_up     = bdcr_pkg::RST_UP_POS;
    logic [bdcr_pkg::POS_W-1:0]  pos_dn     = bdcr_pkg::RST_DOWN_POS;
    logic [bdcr_pkg::POS_W-1:0]  pos_pw     = bdcr_pkg::RST_POWER_POS;

    logic [2:0]        lv_raw = '0;
    logic [2:0]        lv_stable = '0;
    logic [31:0]       chg_ms [3] = '{default: '0};
    logic              chord_on = 1'b0;
    logic              chord_fired = 1'b0;
    logic [31:0]       chord_from_ms = '0;
    logic [31:0]       press_ms [2] = '{default: '0};
    logic [31:0]       repeat_ms [2] = '{default: '0};

    t_poll             polls_to_send [$];
    bdcr_pkg::t_event  events_due [$];
    int                send_idle = 0;
    int                recv_stall = 0;
    bit                hold_arm = 1'b0;
    logic              hold_rx = 1'b0;
    logic [31:0]       t_ms = '0;
    int                bad_results = 0;
    int                n_checked = 0;
    int                ev_count [5] = '{default: 0};
    int unsigned       cycles = 0;

    function automatic logic aged(input logic [31:0] now, input logic [31:0] since,
                                  input logic [bdcr_pkg::CFG_W-1:0] lim);
        logic [31:0] d;
        d = now - since;
        return d >= {16'd0, lim};
    endfunction

    function automatic bdcr_pkg::t_event button_event(input t_poll p);
        logic [2:0]       prev;
        logic [2:0]       raw_now;
        logic             both;
        bdcr_pkg::t_event code;
        int               b;
        prev = lv_stable;
        raw_now = {~p.port[pos_pw], ~p.port[pos_dn], ~p.port[pos_up]};
        for (b = 0; b < 3; b++) begin
            if (lv_raw[b] != raw_now[b]) begin
                lv_raw[b] = raw_now[b];
                chg_ms[b] = p.now;
            end
            if (aged(p.now, chg_ms[b], cfg_db))
                lv_stable[b] = raw_now[b];
        end
        both = lv_stable[0] & lv_stable[1];
        if (both) begin
            if (!chord_on) begin
                chord_on = 1'b1;
                chord_from_ms = p.now;
            end
            if (!chord_fired && aged(p.now, chord_from_ms, cfg_chord)) begin
                chord_fired = 1'b1;
                return bdcr_pkg::EV_CHORD;
            end
        end else begin
            chord_on = 1'b0;
            chord_fired = 1'b0;
        end
        if (!prev[2] && lv_stable[2])
            return bdcr_pkg::EV_POWER;
        if (!both) begin
            for (b = 0; b < 2; b++) begin
                if (b == 0)
                    code = bdcr_pkg::EV_UP;
                else
                    code = bdcr_pkg::EV_DOWN;
                if (lv_stable[b] && !prev[b]) begin
                    press_ms[b] = p.now;
                    repeat_ms[b] = p.now;
                    return code;
                end
                if (lv_stable[b] && prev[b] && aged(p.now, press_ms[b], cfg_delay) &&
                    aged(p.now, repeat_ms[b], cfg_intvl)) begin
                    repeat_ms[b] = p.now;
                    return code;
                end
            end
        end
        return bdcr_pkg::EV_NONE;
    endfunction

    function automatic logic [7:0] make_port(input logic [2:0] pressed);
        logic [7:0] p;
        p = 8'($urandom);
        p[pos_up] = ~pressed[0];
        p[pos_dn] = ~pressed[1];
        p[pos_pw] = ~pressed[2];
        return p;
    endfunction

    function automatic void push_poll(input logic [7:0] port, input logic [31:0] now);
        polls_to_send.push_back({port, now});
    endfunction

    // driver
    always @(posedge i_clk) begin : drive
        t_poll p;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                events_due.push_back(button_event({i_port_bits, i_now_ms}));
            if (!i_valid || o_ready) begin
                if (polls_to_send.size() > 0 && $urandom_range(99) >= send_idle) begin
                    p = polls_to_send.pop_front();
                    i_valid <= 1'b1;
                    i_port_bits <= p.port;
                    i_now_ms <= p.now;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        bdcr_pkg::t_event want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                n_checked++;
                if (o_event_code <= bdcr_pkg::EV_CHORD)
                    ev_count[o_event_code]++;
                if (events_due.size() == 0) begin
                    if (bad_results < 10)
                        $display("unexpected event %0d with nothing pending", o_event_code);
                    bad_results++;
                end else begin
                    want = events_due.pop_front();
                    if (o_event_code !== want) begin
                        if (bad_results < 10)
                            $display("event mismatch at result %0d: expected %0d got %0d",
                                     n_checked, want, o_event_code);
                        bad_results++;
                    end
                end
            end
            i_ready <= !(hold_rx || ($urandom_range(99) < recv_stall));
        end
    end

    // long receiver hold-off
    always begin
        wait (hold_arm);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge i_clk);
        hold_rx <= 1'b0;
        hold_arm = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("button_debounce_chord_repeat_top verification failed");
            $finish;
        end
    end

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (polls_to_send.size() != 0 || i_valid || events_due.size() != 0 || hold_rx);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bdcr_pkg::IDX_W-1:0] idx,
                             input logic [bdcr_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            bdcr_pkg::CFG_DEBOUNCE:   cfg_db = val;
            bdcr_pkg::CFG_CHORD_HOLD: cfg_chord = val;
            bdcr_pkg::CFG_REP_DELAY:  cfg_delay = val;
            bdcr_pkg::CFG_REP_INTVL:  cfg_intvl = val;
            bdcr_pkg::CFG_UP_POS:     pos_up = val[bdcr_pkg::POS_W-1:0];
            bdcr_pkg::CFG_DOWN_POS:   pos_dn = val[bdcr_pkg::POS_W-1:0];
            bdcr_pkg::CFG_POWER_POS:  pos_pw = val[bdcr_pkg::POS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [bdcr_pkg::CFG_W-1:0] db,
                                input logic [bdcr_pkg::CFG_W-1:0] chord,
                                input logic [bdcr_pkg::CFG_W-1:0] delay,
                                input logic [bdcr_pkg::CFG_W-1:0] intvl,
                                input logic [bdcr_pkg::POS_W-1:0] up,
                                input logic [bdcr_pkg::POS_W-1:0] dn,
                                input logic [bdcr_pkg::POS_W-1:0] pw);
        write_reg(bdcr_pkg::CFG_DEBOUNCE, db);
        write_reg(bdcr_pkg::CFG_CHORD_HOLD, chord);
        write_reg(bdcr_pkg::CFG_REP_DELAY, delay);
        write_reg(bdcr_pkg::CFG_REP_INTVL, intvl);
        write_reg(bdcr_pkg::CFG_UP_POS, {13'd0, up});
        write_reg(bdcr_pkg::CFG_DOWN_POS, {13'd0, dn});
        write_reg(bdcr_pkg::CFG_POWER_POS, {13'd0, pw});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic pace(input int s, input int r);
        @(negedge i_clk);
        send_idle = s;
        recv_stall = r;
    endtask

    task automatic queue_polls(input int n, input int unsigned step_max);
        int         added;
        int         hold;
        int         k;
        logic [2:0] pressed;
        logic [7:0] port;
        added = 0;
        while (added < n) begin
            if ($urandom_range(99) < 80) begin
                pressed = 3'($urandom);
                port = make_port(pressed);
                hold = $urandom_range(1, 20);
                for (k = 0; k < hold && added < n; k++) begin
                    t_ms += $urandom_range(0, step_max);
                    if ($urandom_range(19) == 0)
                        push_poll(port ^ (8'd1 << $urandom_range(7)), t_ms);
                    else
                        push_poll(port, t_ms);
                    added++;
                end
            end else begin
                if ($urandom_range(1) == 1)
                    t_ms = $urandom;
                push_poll(8'($urandom), t_ms);
                added++;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_poll(8'hFF, 32'd0);
        push_poll(8'h00, 32'd1);
        push_poll(8'h00, 32'd40);
        push_poll(8'h00, 32'd1040);
        push_poll(8'hFF, 32'd1050);
        push_poll(8'hFF, 32'd1100);
        push_poll(8'hFE, 32'd1200);
        push_poll(8'hFE, 32'd1230);
        push_poll(8'hFE, 32'd1680);
        push_poll(8'hFE, 32'd1700);
        push_poll(8'hFE, 32'd1980);
        push_poll(8'hFD, 32'd2000);
        push_poll(8'hFD, 32'd2030);
        push_poll(8'hFC, 32'd2100);
        push_poll(8'hFC, 32'd2130);
        push_poll(8'hFD, 32'd2140);
        push_poll(8'hFD, 32'd2170);
        push_poll(8'hFD, 32'd2500);
        push_poll(8'hFB, 32'd2600);
        push_poll(8'hFB, 32'd2630);
        push_poll(8'hFE, 32'hFFFF_FFF0);
        push_poll(8'hFE, 32'h0000_000E);
        push_poll(8'h7F, 32'hFFFF_FFFF);
        push_poll(8'h80, 32'h8000_0000);
        wait_drained();

        program_regs(16'd5, 16'd40, 16'd20, 16'd8, 3'd0, 3'd1, 3'd2);
        pace(0, 0);
        t_ms = 32'd5000;
        queue_polls(150, 4);
        wait_drained();

        program_regs(16'd0, 16'd0, 16'd0, 16'd0, 3'd7, 3'd7, 3'd7);
        pace(88, 0);
        queue_polls(120, 3);
        wait_drained();

        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7, 3'd6, 3'd5);
        pace(0, 88);
        queue_polls(100, 20000);
        wait_drained();

        program_regs(16'($urandom_range(0, 8)), 16'($urandom_range(0, 80)),
                     16'($urandom_range(0, 30)), 16'($urandom_range(0, 12)),
                     3'($urandom), 3'($urandom), 3'($urandom));
        pace(6, 6);
        queue_polls(150, 5);
        wait_drained();

        program_regs(16'd3, 16'd25, 16'd10, 16'd4, 3'd4, 3'd5, 3'd6);
        pace(0, 0);
        hold_arm = 1'b1;
        queue_polls(150, 3);
        wait_drained();

        program_regs(bdcr_pkg::RST_DEBOUNCE, bdcr_pkg::RST_CHORD_HOLD,
                     bdcr_pkg::RST_REP_DELAY, bdcr_pkg::RST_REP_INTVL,
                     bdcr_pkg::RST_UP_POS, bdcr_pkg::RST_DOWN_POS, bdcr_pkg::RST_POWER_POS);
        pace(0, 0);
        queue_polls(80, 40);
        wait_drained();

        repeat (4) @(posedge i_clk);
        if (events_due.size() != 0)
            bad_results++;
        $display("checked %0d polls over seven register settings, zero, maximum and shared",
                 n_checked);
        $display("bit positions included; events up %0d down %0d power %0d chord %0d",
                 ev_count[bdcr_pkg::EV_UP], ev_count[bdcr_pkg::EV_DOWN],
                 ev_count[bdcr_pkg::EV_POWER], ev_count[bdcr_pkg::EV_CHORD]);
        if (bad_results == 0)
            $display("button_debounce_chord_repeat_top verification clean");
        else
            $display("button_debounce_chord_repeat_top verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/bdcr_pkg.sv
src/bdcr_debounce.sv
src/button_debounce_chord_repeat_top.sv
dv/button_debounce_chord_repeat_top_tb.sv
